// File: rtl/igrid_pkg.sv
// Package for the Ising grid energy block: shared widths, reset values,
// register indexes and the per-site flag struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package igrid_pkg;

  // Fixed field widths
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned ENERGY_W = 32;
  localparam int unsigned CFG_W    = 7;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_ROWS_DEF   = 64;
  localparam int unsigned MAX_COLS_DEF   = 64;
  localparam int unsigned COUPLING_W_DEF = 16;

  // Configuration port geometry
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] ROWS_RST     = 7'd8;
  localparam logic [CFG_W-1:0] COLS_RST     = 7'd8;
  localparam logic             PERIODIC_RST = 1'b0;

  // Register indexes (byte address divided by four)
  typedef enum logic [1:0] {
    REG_ROWS     = 2'd0,
    REG_COLS     = 2'd1,
    REG_PERIODIC = 2'd2
  } reg_idx_e;

  // Position flags of one site, passed from the input stage to the energy stage
  typedef struct packed {
    logic col_first;
    logic row_first;
    logic last_col;
    logic bottom_row;
    logic periodic;
  } site_flags_t;

endpackage

`default_nettype wire

// File: rtl/igrid_linebuf.sv
// Line buffer: one write port, one registered read port, and a bypass for
// a read that hits the entry written at the same clock edge. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module igrid_linebuf #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 17,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] byp_data_q;
  logic             byp_q;

  // Storage write and registered read; a same-edge read sees the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // Remember whether the read collided with a write to the same entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (re_i) begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

// File: rtl/igrid_energy.sv
// Energy stage: sums the field and neighbor-pair terms of one site, adds them
// to the saturating running sum and holds the result request. Uses igrid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igrid_energy #(
  parameter int unsigned COUPLING_WIDTH = igrid_pkg::COUPLING_W_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  input  wire igrid_pkg::site_flags_t              flags_i,
  input  wire logic                                spin_i,
  input  wire logic signed [COUPLING_WIDTH-1:0]    jr_i,
  input  wire logic signed [COUPLING_WIDTH-1:0]    jb_i,
  input  wire logic signed [igrid_pkg::FIELD_W-1:0] h_i,
  input  wire logic                                above_spin_i,
  input  wire logic signed [COUPLING_WIDTH-1:0]    above_jb_i,
  input  wire logic                                first_row_spin_i,
  input  wire logic                                out_stall_i,
  output      logic                                out_valid_o,
  output      logic signed [igrid_pkg::ENERGY_W-1:0] energy_o,
  output      logic                                saturated_o
);

  localparam int unsigned BASE_W = (COUPLING_WIDTH > igrid_pkg::FIELD_W) ?
                                   COUPLING_WIDTH : igrid_pkg::FIELD_W;
  // Five terms of at most BASE_W+1 bits each
  localparam int unsigned DW = BASE_W + 4;
  localparam int unsigned TW = ((DW > igrid_pkg::ENERGY_W) ? DW : igrid_pkg::ENERGY_W) + 2;
  localparam logic signed [TW-1:0] SAT_MAX =
    signed'({{(TW-igrid_pkg::ENERGY_W+1){1'b0}}, {(igrid_pkg::ENERGY_W-1){1'b1}}});
  localparam logic signed [TW-1:0] SAT_MIN =
    signed'({{(TW-igrid_pkg::ENERGY_W+1){1'b1}}, {(igrid_pkg::ENERGY_W-1){1'b0}}});

  logic                                  row_first_spin_q;
  logic                                  left_spin_q;
  logic signed [COUPLING_WIDTH-1:0]      left_jr_q;
  logic signed [igrid_pkg::ENERGY_W-1:0] sum_q;
  logic                                  ovf_q;
  logic                                  out_vld_q;
  logic signed [igrid_pkg::ENERGY_W-1:0] energy_q;
  logic                                  sat_q;

  logic                                  rf_spin;
  logic                                  fr_spin;
  logic signed [DW-1:0]                  t_field;
  logic signed [DW-1:0]                  t_left;
  logic signed [DW-1:0]                  t_wrap_col;
  logic signed [DW-1:0]                  t_above;
  logic signed [DW-1:0]                  t_wrap_row;
  logic signed [DW-1:0]                  delta;
  logic signed [TW-1:0]                  total;
  logic                                  clamp_hi;
  logic                                  clamp_lo;
  logic signed [igrid_pkg::ENERGY_W-1:0] sum_d;
  logic                                  ovf_d;
  logic                                  grid_done;

  // Per-site terms; a pair adds +J for equal spins and -J otherwise.
  // A site of the first row is its own first-row partner when the grid has one row.
  always_comb begin
    rf_spin    = flags_i.col_first ? spin_i : row_first_spin_q;
    fr_spin    = flags_i.row_first ? spin_i : first_row_spin_i;
    t_field    = spin_i ? -DW'(h_i) : DW'(h_i);
    t_left     = '0;
    t_wrap_col = '0;
    t_above    = '0;
    t_wrap_row = '0;
    if (!flags_i.col_first) begin
      t_left = (spin_i == left_spin_q) ? DW'(left_jr_q) : -DW'(left_jr_q);
    end
    if (flags_i.last_col && flags_i.periodic) begin
      t_wrap_col = (spin_i == rf_spin) ? DW'(jr_i) : -DW'(jr_i);
    end
    if (!flags_i.row_first) begin
      t_above = (spin_i == above_spin_i) ? DW'(above_jb_i) : -DW'(above_jb_i);
    end
    if (flags_i.bottom_row && flags_i.periodic) begin
      t_wrap_row = (spin_i == fr_spin) ? DW'(jb_i) : -DW'(jb_i);
    end
    delta = t_field + t_left + t_wrap_col + t_above + t_wrap_row;
  end

  // Saturating accumulate of the site's total.
  always_comb begin
    total    = TW'(sum_q) + TW'(delta);
    clamp_hi = total > SAT_MAX;
    clamp_lo = total < SAT_MIN;
    if (clamp_hi) begin
      sum_d = igrid_pkg::ENERGY_W'(SAT_MAX);
    end else if (clamp_lo) begin
      sum_d = igrid_pkg::ENERGY_W'(SAT_MIN);
    end else begin
      sum_d = igrid_pkg::ENERGY_W'(total);
    end
    ovf_d     = ovf_q || clamp_hi || clamp_lo;
    grid_done = flags_i.last_col && flags_i.bottom_row;
  end

  // Running state of the grid; it returns to zero after the final site.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_first_spin_q <= 1'b0;
      left_spin_q      <= 1'b0;
      left_jr_q        <= '0;
      sum_q            <= '0;
      ovf_q            <= 1'b0;
    end else if (adv_i) begin
      if (grid_done) begin
        row_first_spin_q <= 1'b0;
        left_spin_q      <= 1'b0;
        left_jr_q        <= '0;
        sum_q            <= '0;
        ovf_q            <= 1'b0;
      end else begin
        row_first_spin_q <= rf_spin;
        left_spin_q      <= spin_i;
        left_jr_q        <= jr_i;
        sum_q            <= sum_d;
        ovf_q            <= ovf_d;
      end
    end
  end

  // Result request valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_i && grid_done) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && grid_done) begin
      energy_q <= sum_d;
      sat_q    <= ovf_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign energy_o    = energy_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  // A result is only loaded into a free or draining result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && grid_done) |-> (!out_vld_q || !out_stall_i))
    else $error("result overwritten while still held");

  // A new result request only follows the final site of a grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv_i && grid_done))
    else $error("result request without final site");
`endif

endmodule

`default_nettype wire

// File: rtl/ising_grid_energy.sv
// The final site is held in the input stage, then its result in the result register.
// One site per cycle, unless a final site waits on a stalled result; the line buffers
// read a column per cycle via a registered port; the sum and saturation are combinational.
// Reset clears the indexes, the running sum, the requests and the above-row valid bits;
// registers return to 8 rows, 8 columns, open boundary. Line buffer data is not cleared.
// Depends on igrid_pkg, igrid_linebuf and igrid_energy.
`timescale 1ns / 1ps
`default_nettype none

module ising_grid_energy #(
  parameter int unsigned MAX_ROWS       = igrid_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS    = igrid_pkg::MAX_COLS_DEF,
  parameter int unsigned COUPLING_WIDTH = igrid_pkg::COUPLING_W_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Site requests
  input  wire logic                                  in_valid_i,
  output      logic                                  in_stall_o,
  input  wire logic                                  spin_bit_i,
  input  wire logic signed [COUPLING_WIDTH-1:0]      right_coupling_i,
  input  wire logic signed [COUPLING_WIDTH-1:0]      below_coupling_i,
  input  wire logic signed [igrid_pkg::FIELD_W-1:0]  site_field_i,
  // Result requests
  output      logic                                  out_valid_o,
  input  wire logic                                  out_stall_i,
  output      logic signed [igrid_pkg::ENERGY_W-1:0] energy_o,
  output      logic                                  saturated_o,
  // Configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [igrid_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [igrid_pkg::APB_DATA_W-1:0]      pwdata,
  output      logic [igrid_pkg::APB_DATA_W-1:0]      prdata,
  output      logic                                  pready
);

  localparam int unsigned RC_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CC_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CI_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Configuration registers
  logic [igrid_pkg::CFG_W-1:0] rows_cfg_q;
  logic [igrid_pkg::CFG_W-1:0] cols_cfg_q;
  logic                        periodic_q;
  logic                        cfg_wr;
  igrid_pkg::reg_idx_e         reg_idx;

  // Grid position
  logic [RI_W-1:0] row_q;
  logic [CI_W-1:0] col_q;
  logic [RC_W-1:0] rows_eff;
  logic [CC_W-1:0] cols_eff;
  logic [RI_W-1:0] r_cur;
  logic [CI_W-1:0] c_cur;
  logic            bottom_row;
  logic            last_col;

  // Input stage
  logic                                 acc;
  logic                                 adv;
  logic                                 s0_vld_q;
  igrid_pkg::site_flags_t               flags_d;
  igrid_pkg::site_flags_t               flags_q;
  logic                                 spin_q;
  logic signed [COUPLING_WIDTH-1:0]     jr_q;
  logic signed [COUPLING_WIDTH-1:0]     jb_q;
  logic signed [igrid_pkg::FIELD_W-1:0] h_q;
  logic [CI_W-1:0]                      c_q;

  // Line buffer read side
  logic [MAX_COLUMNS-1:0]           above_vld_q;
  logic                             above_vld_rd_q;
  logic [COUPLING_WIDTH:0]          above_rd;
  logic [0:0]                       first_rd;
  logic                             above_spin;
  logic                             out_valid;

  // Configuration writes and reads
  assign reg_idx = igrid_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= igrid_pkg::ROWS_RST;
      cols_cfg_q <= igrid_pkg::COLS_RST;
      periodic_q <= igrid_pkg::PERIODIC_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        igrid_pkg::REG_ROWS:     rows_cfg_q <= pwdata[igrid_pkg::CFG_W-1:0];
        igrid_pkg::REG_COLS:     cols_cfg_q <= pwdata[igrid_pkg::CFG_W-1:0];
        igrid_pkg::REG_PERIODIC: periodic_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      igrid_pkg::REG_ROWS:     prdata = igrid_pkg::APB_DATA_W'(rows_cfg_q);
      igrid_pkg::REG_COLS:     prdata = igrid_pkg::APB_DATA_W'(cols_cfg_q);
      igrid_pkg::REG_PERIODIC: prdata = igrid_pkg::APB_DATA_W'(periodic_q);
      default:                 prdata = '0;
    endcase
  end

  // Effective grid size: zero counts as one, values above the bound clamp.
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = RC_W'(1);
    end else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = RC_W'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_eff = CC_W'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLUMNS)) begin
      cols_eff = CC_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CC_W'(cols_cfg_q);
    end
  end

  // Position of the incoming site; an index past the end counts as the last.
  always_comb begin
    r_cur      = (RC_W'(row_q) >= rows_eff) ? RI_W'(rows_eff - RC_W'(1)) : row_q;
    c_cur      = (CC_W'(col_q) >= cols_eff) ? CI_W'(cols_eff - CC_W'(1)) : col_q;
    bottom_row = (RC_W'(r_cur) == rows_eff - RC_W'(1));
    last_col   = (CC_W'(c_cur) == cols_eff - CC_W'(1));
    flags_d.col_first  = (c_cur == '0);
    flags_d.row_first  = (r_cur == '0);
    flags_d.last_col   = last_col;
    flags_d.bottom_row = bottom_row;
    flags_d.periodic   = periodic_q;
  end

  // Handshake: the input stage drains unless its result cannot be stored.
  assign adv = s0_vld_q &&
               (!(flags_q.last_col && flags_q.bottom_row) || !out_valid || !out_stall_i);
  assign in_stall_o = s0_vld_q && !adv;
  assign acc        = in_valid_i && !in_stall_o;

  // Raster counters advance as each site is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= bottom_row ? '0 : r_cur + RI_W'(1);
      end else begin
        col_q <= c_cur + CI_W'(1);
        row_q <= r_cur;
      end
    end
  end

  // Input stage valid flag and position flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      flags_q  <= '0;
    end else if (acc) begin
      s0_vld_q <= 1'b1;
      flags_q  <= flags_d;
    end else if (adv) begin
      s0_vld_q <= 1'b0;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      spin_q <= spin_bit_i;
      jr_q   <= right_coupling_i;
      jb_q   <= below_coupling_i;
      h_q    <= site_field_i;
      c_q    <= c_cur;
    end
  end

  // Above-row spins read as zero until their column is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_vld_q    <= '0;
      above_vld_rd_q <= 1'b0;
    end else begin
      if (adv) begin
        above_vld_q[c_q] <= 1'b1;
      end
      if (acc) begin
        above_vld_rd_q <= above_vld_q[c_cur] || (adv && (c_q == c_cur));
      end
    end
  end

  // Row above: spin and below coupling of each column.
  igrid_linebuf #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (COUPLING_WIDTH + 1),
    .AW    (CI_W)
  ) u_above_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (adv),
    .waddr_i (c_q),
    .wdata_i ({spin_q, jb_q}),
    .re_i    (acc),
    .raddr_i (c_cur),
    .rdata_o (above_rd)
  );

  // First-row spins for the wrap from the last row.
  igrid_linebuf #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (1),
    .AW    (CI_W)
  ) u_first_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (adv && flags_q.row_first),
    .waddr_i (c_q),
    .wdata_i (spin_q),
    .re_i    (acc),
    .raddr_i (c_cur),
    .rdata_o (first_rd)
  );

  assign above_spin = above_vld_rd_q && above_rd[COUPLING_WIDTH];

  igrid_energy #(
    .COUPLING_WIDTH (COUPLING_WIDTH)
  ) u_energy (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .flags_i          (flags_q),
    .spin_i           (spin_q),
    .jr_i             (jr_q),
    .jb_i             (jb_q),
    .h_i              (h_q),
    .above_spin_i     (above_spin),
    .above_jb_i       (signed'(above_rd[COUPLING_WIDTH-1:0])),
    .first_row_spin_i (first_rd[0]),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid),
    .energy_o         (energy_o),
    .saturated_o      (saturated_o)
  );

  assign out_valid_o = out_valid;

`ifndef SYNTHESIS
  // The input side is only held back by an occupied input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_vld_q)
    else $error("input stalled with empty input stage");

  // Accepting the final site of a grid restarts the raster at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last_col && bottom_row) |=> (row_q == '0) && (col_q == '0))
    else $error("raster counters not reset after final site");
`endif

endmodule

`default_nettype wire

// File: tb/sv/ising_grid_energy_checker.sv
// Checker for the Ising grid energy block: watches the site, result and configuration
// channels, predicts the grid energy and compares every result. Depends on igrid_pkg.
`timescale 1ns / 1ps

module ising_grid_energy_checker #(
  parameter int unsigned MAX_ROWS       = igrid_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS    = igrid_pkg::MAX_COLS_DEF,
  parameter int unsigned COUPLING_WIDTH = igrid_pkg::COUPLING_W_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Site requests
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic                                  spin_bit_i,
  input  logic signed [COUPLING_WIDTH-1:0]      right_coupling_i,
  input  logic signed [COUPLING_WIDTH-1:0]      below_coupling_i,
  input  logic signed [igrid_pkg::FIELD_W-1:0]  site_field_i,
  // Result requests
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [igrid_pkg::ENERGY_W-1:0] energy_i,
  input  logic                                  saturated_i,
  // Configuration port
  input  logic                                  psel_i,
  input  logic                                  penable_i,
  input  logic                                  pwrite_i,
  input  logic                                  pready_i,
  input  logic [igrid_pkg::APB_ADDR_W-1:0]      paddr_i,
  input  logic [igrid_pkg::APB_DATA_W-1:0]      pwdata_i,
  // Status for the testbench top
  output int unsigned                           pending_o,
  output int unsigned                           errors_o
);

  typedef struct packed {
    logic signed [igrid_pkg::ENERGY_W-1:0] energy;
    logic                                  saturated;
  } energy_result_t;

  // Register copies
  logic [igrid_pkg::CFG_W-1:0] rows_q;
  logic [igrid_pkg::CFG_W-1:0] cols_q;
  logic                        periodic_q;

  // Line buffers and running state of the grid walk
  logic                             above_spin [MAX_COLUMNS];
  logic signed [COUPLING_WIDTH-1:0] above_jb   [MAX_COLUMNS];
  logic                             first_spin [MAX_COLUMNS];
  logic                             row_first_spin;
  logic                             left_spin;
  logic signed [COUPLING_WIDTH-1:0] left_jr;
  longint                           energy_acc;
  logic                             overflow_seen;
  int unsigned                      row_idx;
  int unsigned                      col_idx;

  energy_result_t expected_energies [$];

  // A zero size counts as one, a size above the bound as the bound.
  function automatic int unsigned grid_dim(logic [igrid_pkg::CFG_W-1:0] v,
                                           int unsigned bound);
    if (v == '0) return 1;
    return (v > bound) ? bound : int'(v);
  endfunction

  // Equal spins add the coupling, unequal spins subtract it.
  function automatic longint bond(logic a, logic b, longint j);
    return (a == b) ? j : -j;
  endfunction

  task automatic clear_grid();
    energy_acc     = 0;
    overflow_seen  = 1'b0;
    row_idx        = 0;
    col_idx        = 0;
    left_spin      = 1'b0;
    left_jr        = '0;
    row_first_spin = 1'b0;
  endtask

  // Adds the terms of one site to the running energy and queues the result at grid end.
  task automatic accumulate_site(input logic s,
                                 input logic signed [COUPLING_WIDTH-1:0] jr,
                                 input logic signed [COUPLING_WIDTH-1:0] jb,
                                 input logic signed [igrid_pkg::FIELD_W-1:0] h);
    int unsigned    rows;
    int unsigned    cols;
    int unsigned    r;
    int unsigned    c;
    logic           last_col;
    logic           bottom_row;
    longint         delta;
    longint         total;
    energy_result_t res;
    rows = grid_dim(rows_q, MAX_ROWS);
    cols = grid_dim(cols_q, MAX_COLUMNS);
    r = row_idx;
    c = col_idx;
    if (c >= cols) c = cols - 1;
    if (r >= rows) r = rows - 1;
    last_col   = (c + 1 >= cols);
    bottom_row = (r + 1 >= rows);

    delta = s ? -longint'(h) : longint'(h);

    // Horizontal pairs, with the wrap from the last column to the first.
    if (c == 0) row_first_spin = s;
    else delta += bond(s, left_spin, left_jr);
    if (last_col && periodic_q) delta += bond(s, row_first_spin, jr);

    // Vertical pairs, with the wrap from the last row to the first.
    if (r == 0) first_spin[c] = s;
    else delta += bond(s, above_spin[c], above_jb[c]);
    if (bottom_row && periodic_q) delta += bond(s, first_spin[c], jb);

    // Saturating accumulation.
    total = energy_acc + delta;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
      overflow_seen = 1'b1;
    end else if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
      overflow_seen = 1'b1;
    end
    energy_acc = total;

    above_spin[c] = s;
    above_jb[c]   = jb;
    left_spin     = s;
    left_jr       = jr;

    // Advance the raster position; the final site closes the grid.
    if (last_col) begin
      col_idx = 0;
      if (bottom_row) begin
        res.energy    = energy_acc[igrid_pkg::ENERGY_W-1:0];
        res.saturated = overflow_seen;
        expected_energies.push_back(res);
        clear_grid();
      end else begin
        row_idx = r + 1;
      end
    end else begin
      col_idx = c + 1;
      row_idx = r;
    end
  endtask

  task automatic check_result();
    energy_result_t exp_res;
    if (expected_energies.size() == 0) begin
      $error("result request with none expected: energy %0d saturated %0b",
             energy_i, saturated_i);
      errors_o++;
    end else begin
      exp_res = expected_energies.pop_front();
      if (energy_i !== exp_res.energy) begin
        $error("energy: expected %0d, actual %0d", exp_res.energy, energy_i);
        errors_o++;
      end
      if (saturated_i !== exp_res.saturated) begin
        $error("saturated: expected %0b, actual %0b", exp_res.saturated, saturated_i);
        errors_o++;
      end
    end
  endtask

  // Results are checked before the sites of the same edge are predicted, since a result
  // always trails the site that closes its grid.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     = igrid_pkg::ROWS_RST;
      cols_q     = igrid_pkg::COLS_RST;
      periodic_q = igrid_pkg::PERIODIC_RST;
      for (int k = 0; k < MAX_COLUMNS; k++) begin
        above_spin[k] = 1'b0;
        above_jb[k]   = '0;
        first_spin[k] = 1'b0;
      end
      clear_grid();
      expected_energies.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          igrid_pkg::REG_ROWS:     rows_q     = pwdata_i[igrid_pkg::CFG_W-1:0];
          igrid_pkg::REG_COLS:     cols_q     = pwdata_i[igrid_pkg::CFG_W-1:0];
          igrid_pkg::REG_PERIODIC: periodic_q = pwdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        accumulate_site(spin_bit_i, right_coupling_i, below_coupling_i, site_field_i);
      end
      pending_o = expected_energies.size();
    end
  end

endmodule

// File: tb/sv/tb_ising_grid_energy.sv
// Testbench top for the Ising grid energy block: streams directed and random grids under
// several sizes and boundary modes and gives the verdict. Depends on igrid_pkg, the block
// and ising_grid_energy_checker.
`timescale 1ns / 1ps

module tb_ising_grid_energy;

  localparam int unsigned MAX_R        = igrid_pkg::MAX_ROWS_DEF;
  localparam int unsigned MAX_C        = igrid_pkg::MAX_COLS_DEF;
  localparam int unsigned CW           = igrid_pkg::COUPLING_W_DEF;
  localparam int unsigned SITE_TARGET  = 1350;
  localparam int unsigned GRID_TARGET  = 40;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_SITES    = 192;
  // Address beyond the register list; writes to it are ignored.
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  logic                                  clk_i   = 1'b0;
  logic                                  rst_ni  = 1'b0;
  logic                                  in_valid  = 1'b0;
  logic                                  in_stall;
  logic                                  spin      = 1'b0;
  logic signed [CW-1:0]                  right_j   = '0;
  logic signed [CW-1:0]                  below_j   = '0;
  logic signed [igrid_pkg::FIELD_W-1:0]  field_h   = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [igrid_pkg::ENERGY_W-1:0] energy;
  logic                                  saturated;
  logic                                  psel      = 1'b0;
  logic                                  penable   = 1'b0;
  logic                                  pwrite    = 1'b0;
  logic [igrid_pkg::APB_ADDR_W-1:0]      paddr     = '0;
  logic [igrid_pkg::APB_DATA_W-1:0]      pwdata    = '0;
  logic [igrid_pkg::APB_DATA_W-1:0]      prdata;
  logic                                  pready;

  int unsigned pending;
  int unsigned errors;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 64;
  int unsigned sites_sent    = 0;
  int unsigned grids_sent    = 0;
  int unsigned cur_rows      = igrid_pkg::ROWS_RST;
  int unsigned cur_cols      = igrid_pkg::COLS_RST;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ising_grid_energy #(
    .MAX_ROWS       (MAX_R),
    .MAX_COLUMNS    (MAX_C),
    .COUPLING_WIDTH (CW)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .spin_bit_i       (spin),
    .right_coupling_i (right_j),
    .below_coupling_i (below_j),
    .site_field_i     (field_h),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .energy_o         (energy),
    .saturated_o      (saturated),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  ising_grid_energy_checker #(
    .MAX_ROWS       (MAX_R),
    .MAX_COLUMNS    (MAX_C),
    .COUPLING_WIDTH (CW)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .spin_bit_i       (spin),
    .right_coupling_i (right_j),
    .below_coupling_i (below_j),
    .site_field_i     (field_h),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .energy_i         (energy),
    .saturated_i      (saturated),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pending_o        (pending),
    .errors_o         (errors)
  );

  // The result side stalls at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int unsigned eff_dim(logic [igrid_pkg::CFG_W-1:0] v,
                                          int unsigned bound);
    if (v == '0) return 1;
    return (v > bound) ? bound : int'(v);
  endfunction

  // Couplings and fields lean toward the extremes of Q8.8.
  function automatic logic [15:0] rand_q88();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return r[15:0];
    endcase
  endfunction

  // Mostly small sizes; now and then zero, the bound, or a value above it.
  function automatic logic [igrid_pkg::CFG_W-1:0] pick_dim();
    int v;
    case ($urandom_range(19))
      0: v = 0;
      1: v = 64;
      2: v = $urandom_range(127, 65);
      default: v = $urandom_range(5, 1);
    endcase
    return v[igrid_pkg::CFG_W-1:0];
  endfunction

  // Sends one site request, with random gaps before it, and waits until it is taken.
  task automatic send_site(input logic s, input logic [15:0] jr, input logic [15:0] jb,
                           input logic [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    spin     <= s;
    right_j  <= jr;
    below_j  <= jb;
    field_h  <= h;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    sites_sent++;
  endtask

  // Waits until every expected result has come, then lets the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One write: setup phase, access phase, then the port released and left idle.
  task automatic write_reg(input logic [1:0] idx, input logic [igrid_pkg::CFG_W-1:0] value);
    logic [31:0] r;
    r = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (r & ~32'h7f) | 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_grid(input logic [igrid_pkg::CFG_W-1:0] rows,
                          input logic [igrid_pkg::CFG_W-1:0] cols,
                          input logic periodic);
    settle();
    write_reg(igrid_pkg::REG_ROWS, rows);
    write_reg(igrid_pkg::REG_COLS, cols);
    write_reg(igrid_pkg::REG_PERIODIC, {{(igrid_pkg::CFG_W-1){1'b0}}, periodic});
    cur_rows = eff_dim(rows, MAX_R);
    cur_cols = eff_dim(cols, MAX_C);
  endtask

  // Whole grids of random sites; some grids hold a single spin value throughout.
  task automatic send_random_grids(input int unsigned count);
    int unsigned sites;
    logic        uniform;
    logic        level;
    sites = cur_rows * cur_cols;
    for (int unsigned g = 0; g < count; g++) begin
      uniform = ($urandom_range(3) == 0);
      level   = 1'($urandom_range(1));
      for (int unsigned k = 0; k < sites; k++) begin
        send_site(uniform ? level : 1'($urandom_range(1)), rand_q88(), rand_q88(),
                  rand_q88());
      end
      grids_sent++;
    end
  endtask

  initial begin
    logic [igrid_pkg::CFG_W-1:0] rows_v;
    logic [igrid_pkg::CFG_W-1:0] cols_v;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One grid under the reset configuration: 8 by 8, open boundary.
    send_random_grids(1);

    // Single site torus: the site pairs with itself both ways.
    set_grid(7'd1, 7'd1, 1'b1);
    write_reg(REG_SPARE, 7'd5);
    send_site(1'b1, 16'h7fff, 16'h7fff, 16'h8000);
    send_site(1'b0, 16'h8000, 16'h8000, 16'h8000);
    send_site(1'b1, 16'h8000, 16'h7fff, 16'h7fff);
    send_site(1'b0, 16'h0000, 16'hffff, 16'h7fff);

    // Zero sizes count as one site, open boundary: only the field term remains.
    set_grid(7'd0, 7'd0, 1'b0);
    send_site(1'b1, 16'h7fff, 16'h8000, 16'hffff);
    send_site(1'b0, 16'h8000, 16'h7fff, 16'h0001);

    // Two by two torus, two grids with extreme couplings.
    set_grid(7'd2, 7'd2, 1'b1);
    send_site(1'b1, 16'h7fff, 16'h8000, 16'h8000);
    send_site(1'b1, 16'h8000, 16'h7fff, 16'h7fff);
    send_site(1'b0, 16'h7fff, 16'h7fff, 16'h0000);
    send_site(1'b1, 16'h8000, 16'h8000, 16'hffff);
    send_site(1'b0, 16'h8000, 16'h8000, 16'h8000);
    send_site(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_site(1'b0, 16'h8000, 16'h7fff, 16'h0001);
    send_site(1'b0, 16'h7fff, 16'h8000, 16'h8000);

    // Single row torus: vertical pairs close on the site itself.
    set_grid(7'd1, 7'd3, 1'b1);
    send_site(1'b1, 16'h7fff, 16'h1234, 16'h0100);
    send_site(1'b0, 16'h8000, 16'h7fff, 16'hff00);
    send_site(1'b1, 16'h7fff, 16'h8000, 16'h0080);

    // Single column torus: horizontal pairs close on the site itself.
    set_grid(7'd3, 7'd1, 1'b1);
    send_site(1'b0, 16'h7fff, 16'h7fff, 16'h8000);
    send_site(1'b0, 16'h8000, 16'h8000, 16'h7fff);
    send_site(1'b1, 16'h1234, 16'h8000, 16'h0000);

    // Random phases: a new configuration, then a few whole grids under it.
    while (sites_sent < SITE_TARGET || grids_sent < GRID_TARGET) begin
      if (sites_sent < SITE_TARGET / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 64;
      end else if (sites_sent < 2 * SITE_TARGET / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rows_v = pick_dim();
      cols_v = pick_dim();
      if (eff_dim(rows_v, MAX_R) * eff_dim(cols_v, MAX_C) > MAX_SITES) begin
        cols_v = igrid_pkg::CFG_W'($urandom_range(3, 1));
      end
      set_grid(rows_v, cols_v, 1'($urandom_range(1)));
      send_random_grids($urandom_range(4, 1));
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb_ising_grid_energy OK");
    end else begin
      $display("tb_ising_grid_energy NOT OK");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_ising_grid_energy NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/igrid_pkg.sv
rtl/igrid_linebuf.sv
rtl/igrid_energy.sv
rtl/ising_grid_energy.sv
tb/sv/ising_grid_energy_checker.sv
tb/sv/tb_ising_grid_energy.sv
